// ===== sv/tcce_pkg.sv =====
// Shared types, constants and codes of the text console cursor engine.
package tcce_pkg;

    // Screen geometry.
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLUMNS * ROWS;

    // Internal widths derived from the geometry.
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int NXT_W    = $clog2(CELLS + COLUMNS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int TAB_STOP = 8;
    localparam int TAB_W    = $clog2(TAB_STOP);

    // Fixed field widths of the request payloads.
    localparam int OPCODE_W     = 2;
    localparam int CHAR_W       = 8;
    localparam int CELL_ADDR_W  = 11;
    localparam int CURSOR_POS_W = 11;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    // Command queue depth.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0]    opcode;
        logic [CHAR_W-1:0]      character;
        logic [CELL_ADDR_W-1:0] cell_address;
    } t_in_req;

    typedef struct packed {
        logic [CURSOR_POS_W-1:0] cursor_position;
        logic                    scrolled;
        logic [CHAR_W-1:0]       cell_value;
    } t_out_req;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PRINT,
        CMD_BS,
        CMD_TAB,
        CMD_CR,
        CMD_LF,
        CMD_CLEAR,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CHAR_W-1:0] character;
        logic [ADDR_W-1:0] addr;
        logic              in_range;
    } t_cmd;

    typedef struct packed {
        logic q_full;
        logic init_busy;
    } t_front_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_SCROLL_END,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

// ===== sv/tcce_front.sv =====
// Front end: accepts requests and classifies them into commands.
module tcce_front (
    input  logic                   i_in_valid,
    input  tcce_pkg::t_in_req      i_in_req,
    output logic                   o_in_stall,
    input  tcce_pkg::t_front_status i_status,
    output logic                   o_push,
    output tcce_pkg::t_cmd         o_cmd
);
    import tcce_pkg::*;

    assign o_in_stall = i_status.q_full | i_status.init_busy;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.kind      = CMD_NOP;
        o_cmd.character = i_in_req.character;
        o_cmd.in_range  = (32'(i_in_req.cell_address) < CELLS);
        // Out-of-range addresses read cell zero; the value is masked later.
        o_cmd.addr      = o_cmd.in_range ? ADDR_W'(i_in_req.cell_address) : '0;
        unique case (i_in_req.opcode)
            OP_PUT: begin
                priority if (i_in_req.character == CH_BS) begin
                    o_cmd.kind = CMD_BS;
                end else if (i_in_req.character == CH_TAB) begin
                    o_cmd.kind = CMD_TAB;
                end else if (i_in_req.character == CH_CR) begin
                    o_cmd.kind = CMD_CR;
                end else if (i_in_req.character == CH_LF) begin
                    o_cmd.kind = CMD_LF;
                end else if (i_in_req.character >= CH_PRINT_LO &&
                             i_in_req.character <= CH_PRINT_HI) begin
                    o_cmd.kind = CMD_PRINT;
                end else begin
                    o_cmd.kind = CMD_NOP;
                end
            end
            OP_CLEAR: o_cmd.kind = CMD_CLEAR;
            OP_READ:  o_cmd.kind = CMD_READ;
            OP_NONE:  o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// ===== sv/tcce_cmd_queue.sv =====
// Short command queue between the front end and the back end.
module tcce_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcce_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tcce_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import tcce_pkg::*;

    t_cmd               r_entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_head  = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/tcce_back.sv =====
// Back end: framebuffer, cursor, scroll and clear sweeps and the result register.
module tcce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcce_pkg::t_cmd    i_cmd,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_init_busy,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tcce_pkg::t_out_req o_out_req
);
    import tcce_pkg::*;

    logic [CHAR_W-1:0] mem [CELLS];

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_cursor;
    logic [COL_W-1:0]  r_col;
    t_out_req          r_pend;
    t_out_req          r_out;
    logic              r_out_valid;
    logic              r_wv;
    logic [ADDR_W-1:0] r_wa;
    logic              r_wspace;
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_rd_ok;

    logic              last_idx;
    logic              out_free;
    logic              is_put;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic              load_out;
    logic [ADDR_W:0]   src;

    logic [NXT_W-1:0]  cur_w;
    logic [NXT_W-1:0]  ncur;
    logic [NXT_W-1:0]  cur_dn;
    logic [COL_W:0]    col_sum;
    logic              use_sum;
    logic [COL_W-1:0]  ncol;
    logic [TAB_W:0]    tab_delta;
    logic              scroll_need;
    logic [ADDR_W-1:0] scur;
    logic [COL_W-1:0]  scol;
    logic [ADDR_W-1:0] put_cur;
    logic [COL_W-1:0]  put_col;

    assign last_idx    = (r_idx == ADDR_W'(CELLS - 1));
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign is_put      = (i_cmd.kind != CMD_CLEAR) && (i_cmd.kind != CMD_READ);
    assign src         = {1'b0, r_idx} + (ADDR_W+1)'(COLUMNS);
    assign o_init_busy = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // Cursor arithmetic for one put-character command. The column is kept
    // alongside the linear cursor so that no modulo is needed.
    always_comb begin
        cur_w     = NXT_W'(r_cursor);
        tab_delta = (TAB_W+1)'(TAB_STOP) - {1'b0, r_cursor[TAB_W-1:0]};
        ncur      = cur_w;
        ncol      = r_col;
        col_sum   = '0;
        use_sum   = 1'b0;
        unique case (i_cmd.kind)
            CMD_PRINT: begin
                ncur    = cur_w + 1'b1;
                col_sum = {1'b0, r_col} + 1'b1;
                use_sum = 1'b1;
            end
            CMD_BS: begin
                if (r_cursor != '0) begin
                    ncur = cur_w - 1'b1;
                    ncol = (r_col == '0) ? COL_W'(COLUMNS - 1) : r_col - 1'b1;
                end
            end
            CMD_TAB: begin
                ncur    = (cur_w + NXT_W'(TAB_STOP)) & ~NXT_W'(TAB_STOP - 1);
                col_sum = {1'b0, r_col} + (COL_W+1)'(tab_delta);
                use_sum = 1'b1;
            end
            CMD_CR: begin
                ncur = cur_w - NXT_W'(r_col);
                ncol = '0;
            end
            CMD_LF: begin
                ncur = cur_w + NXT_W'(COLUMNS) - NXT_W'(r_col);
                ncol = '0;
            end
            default: begin
                ncur = cur_w;
            end
        endcase
        if (use_sum) begin
            if (col_sum >= (COL_W+1)'(COLUMNS)) begin
                ncol = COL_W'(col_sum - (COL_W+1)'(COLUMNS));
            end else begin
                ncol = COL_W'(col_sum);
            end
        end
        scroll_need = (ncur >= NXT_W'(CELLS));
        cur_dn      = ncur - NXT_W'(COLUMNS);
        if (cur_dn >= NXT_W'(CELLS)) begin
            scur = ADDR_W'(CELLS - 1);
            scol = COL_W'(COLUMNS - 1);
        end else begin
            scur = ADDR_W'(cur_dn);
            scol = ncol;
        end
        put_cur = scroll_need ? scur : ADDR_W'(ncur);
        put_col = scroll_need ? scol : ncol;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (last_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cmd.kind)
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_READ:  n_state = S_READ;
                        default:   n_state = scroll_need ? S_SCROLL : S_DONE;
                    endcase
                end
            end
            S_READ:       n_state = S_DONE;
            S_SCROLL: begin
                if (last_idx) begin
                    n_state = S_SCROLL_END;
                end
            end
            S_SCROLL_END: n_state = S_DONE;
            S_CLEAR: begin
                if (last_idx) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:      n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = CH_SPACE;
        raddr    = r_idx;
        load_out = 1'b0;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                we = 1'b1;
            end
            S_IDLE: begin
                o_pop = ~i_q_empty;
                if (!i_q_empty && i_cmd.kind == CMD_PRINT) begin
                    we    = 1'b1;
                    waddr = r_cursor;
                    wdata = i_cmd.character;
                end
                raddr = i_cmd.addr;
            end
            S_SCROLL, S_SCROLL_END: begin
                // Copy phase reads one row ahead; the write address and enable are
                // registered behind the read, so the two never meet.
                raddr = (r_idx < ADDR_W'(CELLS - COLUMNS)) ? ADDR_W'(src) : r_idx;
                we    = r_wv;
                waddr = r_wa;
                wdata = r_wspace ? CH_SPACE : r_rd_data;
            end
            S_DONE: begin
                load_out = out_free;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= (r_state == S_SCROLL);
            if (r_state == S_INIT || r_state == S_CLEAR || r_state == S_SCROLL) begin
                r_idx <= last_idx ? '0 : r_idx + 1'b1;
            end
            if (o_pop && is_put) begin
                r_cursor <= put_cur;
                r_col    <= put_col;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa     <= r_idx;
        r_wspace <= (r_idx >= ADDR_W'(CELLS - COLUMNS));
        if (o_pop) begin
            r_rd_ok                <= i_cmd.in_range;
            r_pend.cursor_position <= CURSOR_POS_W'(is_put ? put_cur : r_cursor);
            r_pend.scrolled        <= is_put & scroll_need;
            r_pend.cell_value      <= '0;
        end else if (r_state == S_READ) begin
            r_pend.cell_value <= r_rd_ok ? r_rd_data : '0;
        end
        if (load_out) begin
            r_out <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor < ADDR_W'(CELLS)) && (r_col < COL_W'(COLUMNS)))
        else $error("cursor or column out of range");

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_pop)
        else $error("command taken during the clearing pass");

    a_scroll_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> r_pend.scrolled)
        else $error("scroll sweep without the scrolled flag");

    a_sweep_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL_END) |-> r_wv)
        else $error("last scroll write lost");

endmodule

// ===== sv/text_console_cursor_engine_top.sv =====
// Top level of the text console cursor engine.
//
//  Channel  Direction  Handshake              Payload
//  in       request    i_in_valid/o_in_stall  i_in_req  (t_in_req)
//  out      result     o_out_valid/i_out_stall o_out_req (t_out_req)
//
// In the back end a put-character request goes from S_IDLE to S_DONE, through
// S_SCROLL and S_SCROLL_END when it scrolls; a read goes from S_IDLE through
// S_READ to S_DONE. A scroll or clear sweeps the framebuffer once through its
// single write port, one cell per cycle. After reset a clearing pass fills the
// framebuffer with spaces; o_in_stall stays high until it is done.
// Requests queue up to four deep while the back end is busy or the result
// register waits on i_out_stall.
module text_console_cursor_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcce_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcce_pkg::t_out_req o_out_req
);
    import tcce_pkg::*;

    t_cmd          front_cmd;
    t_cmd          head_cmd;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    logic          init_busy;
    t_front_status front_status;

    assign front_status.q_full    = q_full;
    assign front_status.init_busy = init_busy;

    tcce_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .i_status   (front_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    tcce_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule
